// ----- rtl/core/srtf_pkg.sv -----
// Shared constants, controller state encoding and control bundles of the SRTF scheduler.
package srtf_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF   = 8;

  localparam int unsigned BURST_W = 16;
  localparam int unsigned TID_W   = 8;
  localparam int unsigned STAT_W  = 16;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_PICK = 6'b001000,
    ST_LOAD = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_step;
    logic pick;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done_now;
    logic scan_end;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/srtf_ctrl.sv -----
// Controller state machine of the SRTF scheduler: sequences update, rescan, reload and emit.
module srtf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srtf_pkg::sts_t sts_i,
  output srtf_pkg::cmd_t cmd_o
);

  srtf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srtf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = srtf_pkg::ST_EXEC;
        end
      end
      srtf_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.done_now ? srtf_pkg::ST_SCAN : srtf_pkg::ST_EMIT;
      end
      srtf_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          state_d = srtf_pkg::ST_PICK;
        end
      end
      srtf_pkg::ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = sts_i.found ? srtf_pkg::ST_LOAD : srtf_pkg::ST_EMIT;
      end
      srtf_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = srtf_pkg::ST_EMIT;
      end
      srtf_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = srtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srtf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/srtf_dp.sv -----
// Datapath of the SRTF scheduler: task tables, running-task registers, scan unit, result word.
module srtf_dp #(
  parameter int unsigned SLOTS     = srtf_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = srtf_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = srtf_pkg::ID_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srtf_pkg::cmd_t               cmd_i,
  output srtf_pkg::sts_t               sts_o,
  input  logic                         mode_i,
  input  logic [srtf_pkg::TID_W-1:0]   task_id_i,
  input  logic [srtf_pkg::BURST_W-1:0] burst_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srtf_pkg::TID_W-1:0]   running_id_o,
  output logic                         idle_o,
  output logic                         done_res_o,
  output logic [srtf_pkg::TID_W-1:0]   done_id_o,
  output logic [srtf_pkg::STAT_W-1:0]  turnaround_o,
  output logic [srtf_pkg::STAT_W-1:0]  waiting_o,
  output logic                         preempted_o,
  output logic                         rejected_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned BW = srtf_pkg::BURST_W;
  localparam int unsigned WW = (TIME_BITS > srtf_pkg::STAT_W) ? TIME_BITS : srtf_pkg::STAT_W;

  logic [BW-1:0]        rem_mem  [SLOTS];
  logic [BW-1:0]        brst_mem [SLOTS];
  logic [TIME_BITS-1:0] arr_mem  [SLOTS];
  logic [ID_BITS-1:0]   id_mem   [SLOTS];

  logic [BW-1:0]        rd_rem_q, rd_brst_q;
  logic [TIME_BITS-1:0] rd_arr_q;
  logic [ID_BITS-1:0]   rd_id_q;

  logic                 mode_q;
  logic [ID_BITS-1:0]   tid_q;
  logic [BW-1:0]        burst_q;

  logic [TIME_BITS-1:0] cur_time_q;
  logic [SLOTS-1:0]     valid_q;
  logic                 run_valid_q;
  logic [IW-1:0]        run_slot_q;
  logic [BW-1:0]        run_rem_q, run_brst_q;
  logic [TIME_BITS-1:0] run_arr_q;
  logic [ID_BITS-1:0]   run_id_q;

  logic                 res_done_q, res_pre_q, res_rej_q;
  logic [ID_BITS-1:0]   res_id_q;
  logic [TIME_BITS-1:0] t_q;
  logic [BW-1:0]        dn_brst_q;

  logic [CW-1:0]        scan_cnt_q;
  logic                 cmp_v_q;
  logic [IW-1:0]        cmp_idx_q;
  logic                 found_q;
  logic [IW-1:0]        best_q;
  logic [BW-1:0]        best_rem_q;

  logic                 out_valid_q;
  logic [srtf_pkg::TID_W-1:0]  o_run_id_q, o_done_id_q;
  logic                 o_idle_q, o_done_q, o_pre_q, o_rej_q;
  logic [srtf_pkg::STAT_W-1:0] o_tat_q, o_wait_q;

  logic                 any_free;
  logic [IW-1:0]        free_idx;
  logic [BW-1:0]        rem_dec;
  logic [TIME_BITS-1:0] time_nx, t_w;
  logic                 tick, arrive_ok, take_over, done_now, scan_run, better;
  logic [IW-1:0]        raddr, rem_waddr;
  logic [BW-1:0]        rem_wdata;
  logic                 rem_we;
  logic [WW-1:0]        t_ext, b_ext, w_ext;
  logic [srtf_pkg::STAT_W-1:0] tat_sat, wait_sat;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign any_free  = ~&valid_q;
  assign tick      = !mode_q;
  assign rem_dec   = (run_rem_q == '0) ? '0 : run_rem_q - BW'(1);
  assign time_nx   = (&cur_time_q) ? cur_time_q : cur_time_q + TIME_BITS'(1);
  assign t_w       = (run_arr_q > time_nx) ? '0 : time_nx - run_arr_q;
  assign done_now  = tick && run_valid_q && (rem_dec == '0);
  assign arrive_ok = mode_q && any_free;
  assign take_over = arrive_ok && (!run_valid_q || (burst_q < run_rem_q));
  assign scan_run  = (scan_cnt_q != CW'(SLOTS));
  assign better    = cmp_v_q && valid_q[cmp_idx_q] && (!found_q || (rd_rem_q < best_rem_q));
  assign raddr     = cmd_i.pick ? best_q : scan_cnt_q[IW-1:0];

  assign rem_we    = cmd_i.exec && (arrive_ok || (tick && run_valid_q));
  assign rem_waddr = mode_q ? free_idx : run_slot_q;
  assign rem_wdata = mode_q ? burst_q : rem_dec;

  assign t_ext    = WW'(t_q);
  assign b_ext    = WW'(dn_brst_q);
  assign w_ext    = (t_ext > b_ext) ? t_ext - b_ext : '0;
  assign tat_sat  = (t_ext > WW'({srtf_pkg::STAT_W{1'b1}})) ? '1 : t_ext[srtf_pkg::STAT_W-1:0];
  assign wait_sat = (w_ext > WW'({srtf_pkg::STAT_W{1'b1}})) ? '1 : w_ext[srtf_pkg::STAT_W-1:0];

  assign sts_o.done_now = done_now;
  assign sts_o.scan_end = !scan_run;
  assign sts_o.found    = found_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (cmd_i.exec && arrive_ok) begin
      brst_mem[free_idx] <= burst_q;
      arr_mem[free_idx]  <= cur_time_q;
      id_mem[free_idx]   <= tid_q;
    end
    rd_rem_q  <= rem_mem[raddr];
    rd_brst_q <= brst_mem[raddr];
    rd_arr_q  <= arr_mem[raddr];
    rd_id_q   <= id_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q  <= '0;
      valid_q     <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      scan_cnt_q  <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        if (tick) begin
          cur_time_q <= time_nx;
        end
        if (done_now) begin
          valid_q[run_slot_q] <= 1'b0;
          run_valid_q         <= 1'b0;
          scan_cnt_q          <= '0;
          found_q             <= 1'b0;
        end
        if (arrive_ok) begin
          valid_q[free_idx] <= 1'b1;
        end
        if (take_over) begin
          run_valid_q <= 1'b1;
          run_slot_q  <= free_idx;
        end
      end
      if (cmd_i.scan_step && scan_run) begin
        scan_cnt_q <= scan_cnt_q + CW'(1);
      end
      cmp_v_q <= cmd_i.scan_step && scan_run;
      if (better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load) begin
        run_valid_q <= 1'b1;
        run_slot_q  <= best_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      tid_q   <= ID_BITS'(task_id_i);
      burst_q <= burst_time_i;
    end
    if (cmd_i.exec) begin
      res_done_q <= done_now;
      res_pre_q  <= take_over && run_valid_q;
      res_rej_q  <= mode_q && !any_free;
      res_id_q   <= run_id_q;
      t_q        <= t_w;
      dn_brst_q  <= run_brst_q;
      if (tick && run_valid_q) begin
        run_rem_q <= rem_dec;
      end
      if (take_over) begin
        run_rem_q  <= burst_q;
        run_brst_q <= burst_q;
        run_arr_q  <= cur_time_q;
        run_id_q   <= tid_q;
      end
    end
    cmp_idx_q <= scan_cnt_q[IW-1:0];
    if (better) begin
      best_q     <= cmp_idx_q;
      best_rem_q <= rd_rem_q;
    end
    if (cmd_i.load) begin
      run_rem_q  <= rd_rem_q;
      run_brst_q <= rd_brst_q;
      run_arr_q  <= rd_arr_q;
      run_id_q   <= rd_id_q;
    end
    if (cmd_i.emit) begin
      o_run_id_q  <= run_valid_q ? srtf_pkg::TID_W'(run_id_q) : '0;
      o_idle_q    <= !run_valid_q;
      o_done_q    <= res_done_q;
      o_done_id_q <= res_done_q ? srtf_pkg::TID_W'(res_id_q) : '0;
      o_tat_q     <= res_done_q ? tat_sat : '0;
      o_wait_q    <= res_done_q ? wait_sat : '0;
      o_pre_q     <= res_pre_q;
      o_rej_q     <= res_rej_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign running_id_o = o_run_id_q;
  assign idle_o       = o_idle_q;
  assign done_res_o   = o_done_q;
  assign done_id_o    = o_done_id_q;
  assign turnaround_o = o_tat_q;
  assign waiting_o    = o_wait_q;
  assign preempted_o  = o_pre_q;
  assign rejected_o   = o_rej_q;

endmodule

// ----- rtl/core/srtf_task_scheduler.sv -----
// Top level of the preemptive shortest-remaining-time-first task scheduler.
// Each input word is a time tick (mode 0) or a task arrival (mode 1) and yields
// exactly one result word. A word is taken in state IDLE, updated in state EXEC
// and its result is registered in state EMIT, which waits until the output side
// is free. A tick that completes the running task adds a linear scan of the task
// table through its registered read port in state SCAN, then state PICK to
// address the winner and, if one was found, state LOAD to load it. The table
// needs no clearing after reset; only its per-slot valid flags are reset.
module srtf_task_scheduler #(
  parameter int unsigned SLOTS     = srtf_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = srtf_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = srtf_pkg::ID_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [srtf_pkg::TID_W-1:0]   task_id_i,
  input  logic [srtf_pkg::BURST_W-1:0] burst_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srtf_pkg::TID_W-1:0]   running_id_o,
  output logic                         idle_o,
  output logic                         done_res_o,
  output logic [srtf_pkg::TID_W-1:0]   done_id_o,
  output logic [srtf_pkg::STAT_W-1:0]  turnaround_o,
  output logic [srtf_pkg::STAT_W-1:0]  waiting_o,
  output logic                         preempted_o,
  output logic                         rejected_o
);

  srtf_pkg::cmd_t cmd;
  srtf_pkg::sts_t sts;

  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srtf_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .task_id_i    (task_id_i),
    .burst_time_i (burst_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .running_id_o (running_id_o),
    .idle_o       (idle_o),
    .done_res_o   (done_res_o),
    .done_id_o    (done_id_o),
    .turnaround_o (turnaround_o),
    .waiting_o    (waiting_o),
    .preempted_o  (preempted_o),
    .rejected_o   (rejected_o)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in flight");

  a_preempt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && preempted_o |-> !idle_o && !done_res_o && !rejected_o)
    else $error("preemption flagged with a conflicting result");

  a_full_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> !idle_o && !preempted_o)
    else $error("full table reported while no task runs");

  a_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step |-> !in_ready_o && !cmd.emit)
    else $error("table scan overlaps input or emit");
`endif

endmodule
